// ===== src/hfit_pkg.sv =====
// ----------------------------------------------------------------------------
// hfit_pkg: shared constants for the handle find-or-insert table
// Field widths of the request and result channels and the default table
// depth handed to the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hfit_pkg;

    // Width of one buffer handle.
    localparam int HANDLE_W = 32;

    // Width of the window fields and of the slot index result.
    localparam int WIN_W = 7;

    // Default number of table entries.
    localparam int DEFAULT_TABLE_DEPTH = 64;

endpackage : hfit_pkg

// ===== src/handle_find_or_insert_table_core.sv =====
// ----------------------------------------------------------------------------
// handle_find_or_insert_table_core: find-or-insert table of buffer handles
// Scans a window of a handle table for a match and appends the handle at the
// fill count when it is not found and the table is not full, else reports overflow.
// ----------------------------------------------------------------------------
// Usage:
//   A request (handle, window start, window size) is taken at a rising edge
//   where start is high and busy is low. busy stays high until the result is
//   issued. The result (slot index, appended, overflow) is presented for one
//   cycle with o_result_valid high; the receiver cannot stall it and must
//   take it in that cycle. A new request may be issued in the result cycle.
// Timing:
//   A setup state computes the window, then the scan reads one table entry
//   per cycle through the single-port synchronous memory and compares it in
//   the next cycle. The scan stops at the first matching entry or after the
//   last written entry of the window; the result strobe is registered from
//   the finishing cycle of the scan.
// Reset:
//   Reset clears the fill count and the control state. Table contents are not
//   cleared; only entries below the fill count are ever read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module handle_find_or_insert_table_core
    import hfit_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [HANDLE_W-1:0] i_handle,
    input  logic [WIN_W-1:0]    i_window_start,
    input  logic [WIN_W-1:0]    i_window_size,
    output logic                o_result_valid,
    output logic [WIN_W-1:0]    o_slot_index,
    output logic                o_appended,
    output logic                o_overflow
);

    // Address, fill count and scan arithmetic widths.
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int SW = ((CW > WIN_W) ? CW : WIN_W) + 1;
    localparam logic [SW-1:0] DEPTH_X = SW'(TABLE_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SETUP,
        S_SCAN
    } t_state;

    // Handle storage.
    logic [HANDLE_W-1:0] r_mem [TABLE_DEPTH];
    logic [HANDLE_W-1:0] r_rdata;

    // Control and request registers.
    t_state              r_state;
    logic [CW-1:0]       r_fill;
    logic [HANDLE_W-1:0] r_handle;
    logic [WIN_W-1:0]    r_start;
    logic [WIN_W-1:0]    r_size;
    logic [SW-1:0]       r_n;
    logic [SW-1:0]       r_m;
    logic [SW-1:0]       r_k;
    logic [SW-1:0]       r_cmp_k;
    logic                r_cmp_valid;
    logic                r_valid;
    logic [WIN_W-1:0]    r_slot;
    logic                r_appended;
    logic                r_overflow;

    // Window arithmetic for the setup cycle.
    logic [SW-1:0] start_x;
    logic [SW-1:0] size_x;
    logic [SW-1:0] fill_x;
    logic [SW-1:0] avail;
    logic [SW-1:0] room;
    logic [SW-1:0] n_n;
    logic [SW-1:0] n_m;

    // Scan control.
    logic          issue;
    logic          hit;
    logic          finish;
    logic [SW-1:0] addr_x;
    logic [AW-1:0] rd_addr;
    logic          wr_en;

    // Window length and the number of written entries inside it.
    always_comb begin
        start_x = SW'(r_start);
        size_x  = SW'(r_size);
        fill_x  = SW'(r_fill);
        avail   = (start_x < fill_x) ? (fill_x - start_x) : '0;
        room    = (start_x < DEPTH_X) ? (DEPTH_X - start_x) : '0;
        n_n     = (r_size != '0) ? size_x : avail;
        if (n_n > room) begin
            n_n = room;
        end
        n_m     = (n_n < avail) ? n_n : avail;
    end

    // Scan pipeline: issue one read per cycle, compare in the next cycle.
    always_comb begin
        hit     = r_cmp_valid && (r_rdata == r_handle);
        issue   = (r_state == S_SCAN) && !hit && (r_k < r_m);
        finish  = (r_state == S_SCAN) && (hit || (r_k >= r_m));
        addr_x  = start_x + r_k;
        rd_addr = addr_x[AW-1:0];
        wr_en   = finish && !hit && (r_fill != DEPTH_C);
    end

    // Table memory with registered read data.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_fill[AW-1:0]] <= r_handle;
        end
        if (issue) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // State machine, fill count and registered result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_cmp_valid <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            // The result strobe lasts exactly the cycle after the scan ends.
            r_valid <= finish;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_handle <= i_handle;
                        r_start  <= i_window_start;
                        r_size   <= i_window_size;
                        r_state  <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    r_n         <= n_n;
                    r_m         <= n_m;
                    r_k         <= '0;
                    r_cmp_valid <= 1'b0;
                    r_state     <= S_SCAN;
                end
                S_SCAN: begin
                    // No read is issued in the finishing cycle, so this also
                    // clears the compare slot at the end of a scan.
                    r_cmp_valid <= issue;
                    r_cmp_k     <= r_k;
                    if (issue) begin
                        r_k <= r_k + 1'b1;
                    end
                    if (finish) begin
                        r_state     <= S_IDLE;
                        if (hit) begin
                            r_slot     <= r_cmp_k[WIN_W-1:0];
                            r_appended <= 1'b0;
                            r_overflow <= 1'b0;
                        end else if (r_fill != DEPTH_C) begin
                            r_slot     <= r_n[WIN_W-1:0];
                            r_appended <= 1'b1;
                            r_overflow <= 1'b0;
                            r_fill     <= r_fill + 1'b1;
                        end else begin
                            r_slot     <= '0;
                            r_appended <= 1'b0;
                            r_overflow <= 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_valid;
    assign o_slot_index   = r_slot;
    assign o_appended     = r_appended;
    assign o_overflow     = r_overflow;

    // The fill count never passes the table depth.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= DEPTH_C)
        else $error("fill count beyond table depth");

    // A result never carries both appended and overflow.
    a_result_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !(o_appended && o_overflow))
        else $error("appended and overflow both set");

    // The fill count moves only with an appended result.
    a_fill_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill != $past(r_fill)) |-> (o_result_valid && o_appended))
        else $error("fill count changed without an append");

    // Overflow is only reported with a full table.
    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_overflow) |-> (r_fill == DEPTH_C))
        else $error("overflow reported with room left");

    // An accepted request keeps the block busy and gives no result next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_result_valid))
        else $error("request accepted but block not busy");

    // Reads stay inside the written part of the table.
    a_read_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue |-> (addr_x < SW'(r_fill)))
        else $error("read of an unwritten entry");

endmodule : handle_find_or_insert_table_core

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking testbench for handle_find_or_insert_table_core
// Drives find-or-insert requests through the start/busy handshake. A short
// table of directed requests runs first, then random requests in bursts
// with gaps. Typed rows check a hand-written result, others a behavioral model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb
    import hfit_pkg::*;
();

    localparam int DEPTH        = DEFAULT_TABLE_DEPTH;
    localparam int NUM_RANDOM   = 1135;
    localparam int DRAIN_CYCLES = DEPTH + 16;
    localparam int DIR_ROWS     = 13;

    // One result as the block reports it.
    typedef struct packed {
        logic [WIN_W-1:0] slot_index;
        logic             appended;
        logic             overflow;
    } t_lookup_result;

    // One directed request; typed rows carry a hand-written result.
    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [WIN_W-1:0]    wstart;
        logic [WIN_W-1:0]    wsize;
        logic                typed;
        t_lookup_result      want;
    } t_directed_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [HANDLE_W-1:0] i_handle;
    logic [WIN_W-1:0]    i_window_start;
    logic [WIN_W-1:0]    i_window_size;
    logic                o_result_valid;
    logic [WIN_W-1:0]    o_slot_index;
    logic                o_appended;
    logic                o_overflow;

    // Model state of the table.
    logic [HANDLE_W-1:0] model_table [DEPTH];
    int                  model_fill;

    t_lookup_result      pending_results [$];
    t_lookup_result      oldest_result;
    int                  err_count;
    int                  n_requests;
    int                  n_found;
    int                  n_appended;
    int                  n_overflow;

    // Directed requests, starting from an empty table.
    t_directed_row dir_rows [DIR_ROWS] = '{
        // Open window on an empty table appends at entry 0.
        '{32'h0000_0001, 7'd0,   7'd0,   1'b1, '{7'd0,  1'b1, 1'b0}},
        // Same handle again is found at the window start.
        '{32'h0000_0001, 7'd0,   7'd0,   1'b1, '{7'd0,  1'b0, 1'b0}},
        // Full-size window: unwritten entries count as searched.
        '{32'hFFFF_FFFF, 7'd0,   7'd64,  1'b1, '{7'd64, 1'b1, 1'b0}},
        // Start beyond the table end gives an empty window.
        '{32'hFFFF_FFFF, 7'd127, 7'd127, 1'b1, '{7'd0,  1'b1, 1'b0}},
        // Zero handle is an ordinary value.
        '{32'h0000_0000, 7'd0,   7'd0,   1'b0, '0},
        '{32'h0000_0000, 7'd3,   7'd1,   1'b0, '0},
        // Open window starting past the fill count is empty.
        '{32'h0000_0001, 7'd5,   7'd0,   1'b0, '0},
        // Window cut at the last table entry.
        '{32'hA5A5_A5A5, 7'd60,  7'd10,  1'b0, '0},
        '{32'hA5A5_A5A5, 7'd1,   7'd0,   1'b0, '0},
        '{32'h8000_0000, 7'd64,  7'd1,   1'b0, '0},
        '{32'h7FFF_FFFF, 7'd0,   7'd127, 1'b0, '0},
        '{32'h0000_0001, 7'd1,   7'd3,   1'b0, '0},
        '{32'h0000_0001, 7'd4,   7'd2,   1'b0, '0}
    };

    handle_find_or_insert_table_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_handle       (i_handle),
        .i_window_start (i_window_start),
        .i_window_size  (i_window_size),
        .o_result_valid (o_result_valid),
        .o_slot_index   (o_slot_index),
        .o_appended     (o_appended),
        .o_overflow     (o_overflow)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("tb: mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // Finds the handle in the window or appends it, updating the model table.
    function automatic t_lookup_result find_or_insert(input logic [HANDLE_W-1:0] h,
                                                      input logic [WIN_W-1:0] ws,
                                                      input logic [WIN_W-1:0] wz);
        int             n;
        int             s;
        t_lookup_result res;
        s = int'(ws);
        if (wz != '0) begin
            n = int'(wz);
        end else begin
            n = (s < model_fill) ? model_fill - s : 0;
        end
        if (s >= DEPTH) begin
            n = 0;
        end else if (n > DEPTH - s) begin
            n = DEPTH - s;
        end
        // Scan in order; entries past the fill count never match.
        for (int k = 0; k < n; k++) begin
            if (s + k < model_fill && model_table[s + k] == h) begin
                n_found++;
                res = '{WIN_W'(k), 1'b0, 1'b0};
                return res;
            end
        end
        if (model_fill < DEPTH) begin
            model_table[model_fill] = h;
            model_fill++;
            n_appended++;
            res = '{WIN_W'(n), 1'b1, 1'b0};
        end else begin
            n_overflow++;
            res = '{'0, 1'b0, 1'b1};
        end
        return res;
    endfunction

    // Holds a request on the inputs until the block takes it.
    task automatic send_request(input logic [HANDLE_W-1:0] h, input logic [WIN_W-1:0] ws,
                                input logic [WIN_W-1:0] wz, input logic typed,
                                input t_lookup_result want);
        t_lookup_result model_res;
        i_handle       <= h;
        i_window_start <= ws;
        i_window_size  <= wz;
        start          <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        model_res = find_or_insert(h, ws, wz);
        n_requests++;
        pending_results.push_back(typed ? want : model_res);
    endtask

    // Result checker: every strobe must match the oldest pending result.
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no request outstanding",
                                int'(o_slot_index), 0);
            end else begin
                oldest_result = pending_results.pop_front();
                if (o_slot_index !== oldest_result.slot_index)
                    report_mismatch("slot_index", int'(o_slot_index),
                                    int'(oldest_result.slot_index));
                if (o_appended !== oldest_result.appended)
                    report_mismatch("appended", int'(o_appended),
                                    int'(oldest_result.appended));
                if (o_overflow !== oldest_result.overflow)
                    report_mismatch("overflow", int'(o_overflow),
                                    int'(oldest_result.overflow));
            end
        end
    end

    // Stimulus: reset, directed table, then random requests in bursts.
    initial begin
        logic [HANDLE_W-1:0] h;
        logic [WIN_W-1:0]    ws;
        logic [WIN_W-1:0]    wz;
        int                  burst_left;
        int                  gap;
        int                  idx;
        int                  new_pct;
        int                  r;

        err_count      = 0;
        n_requests     = 0;
        n_found        = 0;
        n_appended     = 0;
        n_overflow     = 0;
        model_fill     = 0;
        burst_left     = 0;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_handle       = '0;
        i_window_start = '0;
        i_window_size  = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed requests back to back.
        for (int i = 0; i < DIR_ROWS; i++) begin
            send_request(dir_rows[i].handle, dir_rows[i].wstart, dir_rows[i].wsize,
                         dir_rows[i].typed, dir_rows[i].want);
        end

        for (int i = 0; i < NUM_RANDOM; i++) begin
            // Sender idles between bursts, with junk on the request fields.
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 80)
                                                  : $urandom_range(1, 8);
                start          <= 1'b0;
                i_handle       <= $urandom;
                i_window_start <= WIN_W'($urandom);
                i_window_size  <= WIN_W'($urandom);
                repeat (gap) @(posedge i_clk);
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                         : $urandom_range(1, 16);
            end
            burst_left--;

            // Mostly known handles so the table fills slowly and hits occur.
            new_pct = (model_fill < DEPTH) ? 12 : 25;
            r = $urandom_range(0, 99);
            if (model_fill > 0 && r >= new_pct) begin
                idx = $urandom_range(0, model_fill - 1);
                h = model_table[idx];
                if ($urandom_range(0, 9) < 7) begin
                    // Window that contains the stored entry.
                    ws = WIN_W'($urandom_range(0, idx));
                    wz = ($urandom_range(0, 9) < 3) ? '0
                         : WIN_W'($urandom_range(idx - int'(ws) + 1, DEPTH));
                end else begin
                    ws = WIN_W'($urandom_range(0, DEPTH - 1));
                    wz = WIN_W'($urandom_range(0, DEPTH));
                end
            end else begin
                r = $urandom_range(0, 19);
                h = (r == 0) ? '0 : (r == 1) ? '1 : HANDLE_W'($urandom);
                r = $urandom_range(0, 9);
                ws = (r < 8) ? WIN_W'($urandom_range(0, DEPTH - 1))
                   : (r == 8) ? WIN_W'($urandom_range(DEPTH, 127))
                   : WIN_W'(model_fill);
                r = $urandom_range(0, 19);
                wz = (r < 7) ? '0
                   : (r < 17) ? WIN_W'($urandom_range(1, DEPTH))
                   : WIN_W'($urandom_range(0, 127));
            end
            send_request(h, ws, wz, 1'b0, '0);
        end

        // Drain the last results, then allow one full scan for stray strobes.
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("summary: %0d requests, %0d found, %0d appended, %0d overflowed",
                 n_requests, n_found, n_appended, n_overflow);
        $display("summary: final fill %0d of %0d entries, %0d mismatches",
                 model_fill, DEPTH, err_count);
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule : tb
